// ----- sv/quaternion_similarity_point_transform_top_macros.svh -----
// Assertion macros shared by the checker of the point transform block.
`ifndef QUATERNION_SIMILARITY_POINT_TRANSFORM_TOP_MACROS_SVH
`define QUATERNION_SIMILARITY_POINT_TRANSFORM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QSPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QSPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/qspt_pkg.sv -----
// Shared types and constants for the quaternion point transform block.
package qspt_pkg;

  // Register stages between input and output word
  localparam int PIPE_DEPTH = 6;

  // Configuration register indexes
  typedef enum logic [3:0] {
    REG_POS_X  = 4'd0,
    REG_POS_Y  = 4'd1,
    REG_POS_Z  = 4'd2,
    REG_QUAT_W = 4'd3,
    REG_QUAT_X = 4'd4,
    REG_QUAT_Y = 4'd5,
    REG_QUAT_Z = 4'd6,
    REG_SCALE  = 4'd7
  } cfg_reg_e;

  // Input word: one point, Q16.16
  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } in_word_t;

  // Output word: transformed point and clamp flag
  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } out_word_t;

endpackage

// ----- sv/quaternion_similarity_point_transform_top.sv -----
// Top level: rotate by quaternion, scale and translate one 3D point per word.
// Pipeline: six register stages (cross product, rotation, scale, translate) lie
//   between the accepted input word and the registered output word.
// Throughput: one point per cycle; a stalled output holds the pipeline and
//   bubbles are squeezed out, so stages fill up behind a stall.
// Reset: clears all stage valid bits and loads the identity transform
//   (zero translation, unit quaternion, scale one).
module quaternion_similarity_point_transform_top
  import qspt_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // point input channel
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  in_word_t     in_word_i,
  // result output channel
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output out_word_t    out_word_o,
  // configuration write channel
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  // Intermediate widths, sized so nothing overflows
  localparam int PW = 48;  // q * v
  localparam int DW = 49;  // cross difference plus rounding
  localparam int TW = 36;  // t = 2 (q x v)
  localparam int MW = 52;  // q * t
  localparam int SW = 55;  // three-term rotation sum plus rounding
  localparam int RW = 42;  // rotated vector
  localparam int KW = 59;  // r * scale
  localparam int AW = 60;  // scaled plus rounding
  localparam int FW = 53;  // scaled plus translation

  localparam logic signed [DW-1:0] RND_T = DW'(1) <<< 12;
  localparam logic signed [SW-1:0] RND_R = SW'(1) <<< 13;
  localparam logic signed [AW-1:0] RND_S = AW'(1) <<< 7;
  localparam logic signed [FW-1:0] SAT_HI = FW'(32'sh7fff_ffff);
  localparam logic signed [FW-1:0] SAT_LO = FW'(-64'sh0000_0000_8000_0000);

  // Configuration registers
  logic signed [31:0] pos_q [3];
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  logic        [15:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0] <= '0;
      pos_q[1] <= '0;
      pos_q[2] <= '0;
      qw_q     <= 16'sd16384;
      qx_q     <= '0;
      qy_q     <= '0;
      qz_q     <= '0;
      scale_q  <= 16'd256;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_POS_X:  pos_q[0] <= cfg_data_i;
        REG_POS_Y:  pos_q[1] <= cfg_data_i;
        REG_POS_Z:  pos_q[2] <= cfg_data_i;
        REG_QUAT_W: qw_q     <= cfg_data_i[15:0];
        REG_QUAT_X: qx_q     <= cfg_data_i[15:0];
        REG_QUAT_Y: qy_q     <= cfg_data_i[15:0];
        REG_QUAT_Z: qz_q     <= cfg_data_i[15:0];
        REG_SCALE:  scale_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Stage valids and advance chain: a stage loads when empty or draining
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [PIPE_DEPTH-1:0] adv;

  always_comb begin
    adv[PIPE_DEPTH-1] = !vld_q[PIPE_DEPTH-1] || !out_stall_i;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Stage 1: cross product partial products q x v
  logic signed [31:0] v1_q [3];
  logic signed [PW-1:0] pa1_d [3], pb1_d [3];
  logic signed [PW-1:0] pa1_q [3], pb1_q [3];

  always_comb begin
    pa1_d[0] = qy_q * in_word_i.in_z;
    pb1_d[0] = qz_q * in_word_i.in_y;
    pa1_d[1] = qz_q * in_word_i.in_x;
    pb1_d[1] = qx_q * in_word_i.in_z;
    pa1_d[2] = qx_q * in_word_i.in_y;
    pb1_d[2] = qy_q * in_word_i.in_x;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      v1_q[0] <= in_word_i.in_x;
      v1_q[1] <= in_word_i.in_y;
      v1_q[2] <= in_word_i.in_z;
      pa1_q   <= pa1_d;
      pb1_q   <= pb1_d;
    end
  end

  // Stage 2: t = round((q x v) / 2^13)
  logic signed [31:0]   v2_q [3];
  logic signed [DW-1:0] d2 [3];
  logic signed [TW-1:0] t2_d [3], t2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d2[i]   = DW'(pa1_q[i]) - DW'(pb1_q[i]) + RND_T;
      t2_d[i] = d2[i][DW-1:13];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      v2_q <= v1_q;
      t2_q <= t2_d;
    end
  end

  // Stage 3: products w t and q x t
  logic signed [31:0]   v3_q [3];
  logic signed [MW-1:0] mw3_d [3], ma3_d [3], mb3_d [3];
  logic signed [MW-1:0] mw3_q [3], ma3_q [3], mb3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mw3_d[i] = qw_q * t2_q[i];
    end
    ma3_d[0] = qy_q * t2_q[2];
    mb3_d[0] = qz_q * t2_q[1];
    ma3_d[1] = qz_q * t2_q[0];
    mb3_d[1] = qx_q * t2_q[2];
    ma3_d[2] = qx_q * t2_q[1];
    mb3_d[2] = qy_q * t2_q[0];
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      v3_q  <= v2_q;
      mw3_q <= mw3_d;
      ma3_q <= ma3_d;
      mb3_q <= mb3_d;
    end
  end

  // Stage 4: r = v + round((w t + q x t) / 2^14)
  logic signed [SW-1:0] s4 [3];
  logic signed [RW-1:0] r4_d [3], r4_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4[i]   = SW'(mw3_q[i]) + SW'(ma3_q[i]) - SW'(mb3_q[i]) + RND_R;
      r4_d[i] = RW'(v3_q[i]) + RW'($signed(s4[i][SW-1:14]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      r4_q <= r4_d;
    end
  end

  // Stage 5: uniform scale product
  logic signed [16:0]   sc5;
  logic signed [KW-1:0] k5_d [3], k5_q [3];

  assign sc5 = $signed({1'b0, scale_q});

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      k5_d[i] = r4_q[i] * sc5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      k5_q <= k5_d;
    end
  end

  // Stage 6: round, translate, saturate into the output word
  logic signed [AW-1:0] a6 [3];
  logic signed [FW-1:0] f6 [3];
  logic signed [31:0]   o6 [3];
  logic [2:0]           clip6;
  out_word_t            out_d, out_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a6[i] = AW'(k5_q[i]) + RND_S;
      f6[i] = FW'($signed(a6[i][AW-1:8])) + FW'(pos_q[i]);
      if (f6[i] > SAT_HI) begin
        o6[i]    = 32'sh7fff_ffff;
        clip6[i] = 1'b1;
      end else if (f6[i] < SAT_LO) begin
        o6[i]    = 32'sh8000_0000;
        clip6[i] = 1'b1;
      end else begin
        o6[i]    = f6[i][31:0];
        clip6[i] = 1'b0;
      end
    end
    out_d.out_x     = o6[0];
    out_d.out_y     = o6[1];
    out_d.out_z     = o6[2];
    out_d.saturated = |clip6;
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign out_word_o  = out_q;

endmodule

// ----- sv/qspt_checker.sv -----
// Port-level checker for the point transform block, bound to its top level.
`include "quaternion_similarity_point_transform_top_macros.svh"

module qspt_checker
  import qspt_pkg::*;
(
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input out_word_t    out_word_o
);

  localparam int CW = $clog2(PIPE_DEPTH + 1);

  // Words accepted but not yet delivered
  logic          in_acc, out_acc;
  logic [CW-1:0] inflight_q, inflight_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + CW'(1);
    end else if (out_acc && !in_acc) begin
      inflight_d = inflight_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A stalled output word holds
  `QSPT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  // No word appears that was never accepted
  `QSPT_ASSERT_NOW(a_no_phantom, clk_i, rst_ni, out_valid_o, inflight_q != '0, "output word without accepted input")
  // Pipeline never holds more than its depth
  `QSPT_ASSERT_NOW(a_depth, clk_i, rst_ni, 1'b1, inflight_q <= CW'(PIPE_DEPTH), "more words in flight than stages")
  // Full and stalled pipeline pushes back on the input
  `QSPT_ASSERT_NOW(a_full_stall, clk_i, rst_ni, (inflight_q == CW'(PIPE_DEPTH)) && out_stall_i, in_stall_o, "full stalled pipeline accepts input")
  // Empty output stage never blocks the input
  `QSPT_ASSERT_NOW(a_empty_go, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled while output stage empty")

endmodule

bind quaternion_similarity_point_transform_top qspt_checker u_qspt_checker (.*);
